// File: design/arpc_pkg.sv
package arpc_pkg;

    localparam int unsigned IDX_W = 8;
    localparam logic [15:0] LIFETIME_RESET = 16'd300;

    typedef enum logic [1:0] {
        K_LOOKUP = 2'd0,
        K_UPDATE = 2'd1,
        K_CLEAR  = 2'd2,
        K_FLUSH  = 2'd3
    } t_kind;

    typedef struct packed {
        logic             act;
        t_kind            kind;
        logic [31:0]      ip;
        logic [15:0]      now;
        logic [15:0]      life;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
        logic [47:0]      mac;
        logic [15:0]      hwt;
        logic [7:0]       flags;
    } t_tok;

    typedef struct packed {
        logic             clr;
        logic             wr;
        logic [IDX_W-1:0] wr_idx;
        logic [31:0]      ip;
        logic [47:0]      mac;
        logic [15:0]      hwt;
        logic [7:0]       flags;
        logic [15:0]      stamp;
    } t_ctl;

endpackage

// File: design/arpc_cell.sv
module arpc_cell
    import arpc_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    input  t_ctl i_ctl,
    output t_tok o_tok
);

    localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

    logic        r_valid;
    logic        n_valid;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [15:0] r_hwt;
    logic [7:0]  r_flags;
    logic [15:0] r_stamp;
    t_tok        r_tok;
    t_tok        n_tok;
    logic        w_evict;
    logic        w_match;
    logic        w_sel;
    logic [15:0] w_age;

    assign w_match = r_valid && (r_ip == i_tok.ip);
    assign w_age   = i_tok.now - r_stamp;
    assign w_sel   = i_ctl.wr && (i_ctl.wr_idx == ME);

    always_comb begin
        n_tok   = i_tok;
        w_evict = 1'b0;
        if (i_tok.act) begin
            case (i_tok.kind)
                K_LOOKUP, K_UPDATE: begin
                    if (w_match && !i_tok.hit) begin
                        n_tok.hit     = 1'b1;
                        n_tok.hit_idx = ME;
                        n_tok.mac     = r_mac;
                        n_tok.hwt     = r_hwt;
                        n_tok.flags   = r_flags;
                    end
                    if (i_tok.kind == K_UPDATE && !r_valid && !i_tok.free_ok) begin
                        n_tok.free_ok  = 1'b1;
                        n_tok.free_idx = ME;
                    end
                end
                K_FLUSH: begin
                    if (r_valid && !i_tok.hit && w_age >= i_tok.life) begin
                        n_tok.hit     = 1'b1;
                        n_tok.hit_idx = ME;
                        w_evict       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.clr) begin
            n_valid = 1'b0;
        end else if (w_sel) begin
            n_valid = 1'b1;
        end else if (w_evict) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.act <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_ip    <= i_ctl.ip;
            r_mac   <= i_ctl.mac;
            r_hwt   <= i_ctl.hwt;
            r_flags <= i_ctl.flags;
            r_stamp <= i_ctl.stamp;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: design/arp_cache_table.sv
// ARP cache table. A request is taken when start is high and busy is low; the
// result appears on the o_ ports for one cycle with o_strobe high, ENTRIES + 2
// cycles after the request (18 cycles for 16 entries), and a new request may be
// taken in that same cycle. The receiver cannot stall: a result is gone after
// its strobe cycle. The figure is set by the chain of entry cells, one cell per
// cycle, that every request walks through, plus one cycle to launch it and one
// to write back and register the result. All entries are invalid after reset.
// Register 0 at byte address 0 is the flush lifetime in seconds (reset 300).
module arp_cache_table
    import arpc_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_ip_address,
    input  logic [47:0] i_mac_address,
    input  logic [15:0] i_hw_type,
    input  logic [7:0]  i_entry_flags,
    input  logic [15:0] i_now_seconds,
    output logic        o_strobe,
    output logic        o_found,
    output logic        o_status,
    output logic [3:0]  o_slot,
    output logic [47:0] o_found_mac,
    output logic [15:0] o_found_hw_type,
    output logic [7:0]  o_found_flags,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [15:0]      r_lifetime;
    t_tok             r_inj;
    t_tok             n_inj;
    logic [47:0]      r_mac;
    logic [15:0]      r_hwt;
    logic [7:0]       r_flags;
    t_ctl             w_ctl;
    t_tok             w_tok [ENTRIES+1];
    t_tok             w_last;
    logic             w_accept;
    logic             w_done;
    logic [IDX_W-1:0] w_slot_idx;
    logic             r_strobe;
    logic             r_found;
    logic             r_status;
    logic [3:0]       r_slot;
    logic [47:0]      r_fmac;
    logic [15:0]      r_fhwt;
    logic [7:0]       r_fflags;
    logic             n_found;
    logic             n_status;
    logic [47:0]      n_fmac;
    logic [15:0]      n_fhwt;
    logic [7:0]       n_fflags;

    assign busy     = (r_state == S_RUN);
    assign w_accept = start && !busy;
    assign w_last   = w_tok[ENTRIES];
    assign w_done   = busy && w_last.act;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_lifetime} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= LIFETIME_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_lifetime <= pwdata[15:0];
        end
    end

    // launch
    always_comb begin
        n_inj     = r_inj;
        n_inj.act = 1'b0;
        if (w_accept) begin
            n_inj.act      = 1'b1;
            n_inj.kind     = t_kind'(i_kind);
            n_inj.ip       = i_ip_address;
            n_inj.now      = i_now_seconds;
            n_inj.life     = r_lifetime;
            n_inj.hit      = 1'b0;
            n_inj.hit_idx  = '0;
            n_inj.free_ok  = 1'b0;
            n_inj.free_idx = '0;
            n_inj.mac      = '0;
            n_inj.hwt      = '0;
            n_inj.flags    = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) n_state = S_RUN;
            S_RUN:  if (w_last.act) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_inj.act <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inj    <= n_inj;
            r_strobe <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mac   <= i_mac_address;
            r_hwt   <= i_hw_type;
            r_flags <= i_entry_flags;
        end
    end

    // cell chain
    assign w_tok[0] = r_inj;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        arpc_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_tok[g]),
            .i_ctl  (w_ctl),
            .o_tok  (w_tok[g+1])
        );
    end

    // write back and result
    assign w_slot_idx   = w_last.hit ? w_last.hit_idx : w_last.free_idx;
    assign w_ctl.clr    = w_done && (w_last.kind == K_CLEAR);
    assign w_ctl.wr     = w_done && (w_last.kind == K_UPDATE)
                          && (w_last.hit || w_last.free_ok);
    assign w_ctl.wr_idx = w_slot_idx;
    assign w_ctl.ip     = w_last.ip;
    assign w_ctl.mac    = r_mac;
    assign w_ctl.hwt    = r_hwt;
    assign w_ctl.flags  = r_flags;
    assign w_ctl.stamp  = w_last.now;

    always_comb begin
        n_found  = 1'b0;
        n_status = 1'b0;
        n_fmac   = '0;
        n_fhwt   = '0;
        n_fflags = '0;
        case (w_last.kind)
            K_LOOKUP: begin
                n_found = w_last.hit;
                if (w_last.hit) begin
                    n_fmac   = w_last.mac;
                    n_fhwt   = w_last.hwt;
                    n_fflags = w_last.flags;
                end
            end
            K_UPDATE: n_status = !w_last.hit && !w_last.free_ok;
            K_FLUSH:  n_found = w_last.hit;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_found  <= n_found;
            r_status <= n_status;
            r_slot   <= (w_last.hit || (w_last.kind == K_UPDATE && w_last.free_ok))
                        && w_last.kind != K_CLEAR ? w_slot_idx[3:0] : 4'd0;
            r_fmac   <= n_fmac;
            r_fhwt   <= n_fhwt;
            r_fflags <= n_fflags;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_found         = r_found;
    assign o_status        = r_status;
    assign o_slot          = r_slot;
    assign o_found_mac     = r_fmac;
    assign o_found_hw_type = r_fhwt;
    assign o_found_flags   = r_fflags;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && w_last.act) |=> (o_strobe && !busy))
        else $error("scan finished without result strobe");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status |-> !o_found && o_slot == 4'd0)
        else $error("full status with hit or slot");
`endif

endmodule

// File: tb/sv/arp_cache_table_tb.sv
`timescale 1ns / 100ps

module arp_cache_table_tb;
    import arpc_pkg::*;

    localparam int N_ENTRIES = 16;
    localparam int N_PHASES = 6;
    localparam int PHASE_REQUESTS = 280;
    localparam int POOL_SIZE = 24;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [2:0] ADDR_LIFETIME = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] hwt;
        logic [7:0]  flags;
        logic [15:0] now;
    } t_req;

    typedef struct packed {
        logic        found;
        logic        status;
        logic [3:0]  slot;
        logic [47:0] mac;
        logic [15:0] hwt;
        logic [7:0]  flags;
    } t_reply;

    typedef struct {
        t_req   req;
        bit     pinned;
        t_reply want;
    } t_row;

    localparam t_reply NO_REPLY = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [31:0] i_ip_address;
    logic [47:0] i_mac_address;
    logic [15:0] i_hw_type;
    logic [7:0]  i_entry_flags;
    logic [15:0] i_now_seconds;
    logic        o_strobe;
    logic        o_found;
    logic        o_status;
    logic [3:0]  o_slot;
    logic [47:0] o_found_mac;
    logic [15:0] o_found_hw_type;
    logic [7:0]  o_found_flags;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    arp_cache_table #(.ENTRIES(N_ENTRIES)) dut (.*);

    // shadow copy of the table
    logic [N_ENTRIES-1:0] entry_valid;
    logic [31:0]          entry_ip    [N_ENTRIES];
    logic [47:0]          entry_mac   [N_ENTRIES];
    logic [15:0]          entry_hwt   [N_ENTRIES];
    logic [7:0]           entry_flags [N_ENTRIES];
    logic [15:0]          entry_stamp [N_ENTRIES];
    logic [15:0]          life_secs;

    t_reply pending_replies[$];
    t_row   plan[$];
    int     mismatches;
    int     quiet_cycles;
    int     n_lookups, n_hits, n_updates, n_full, n_flushes, n_evictions, n_clears;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int find_ip(logic [31:0] ip);
        int i;
        for (i = 0; i < N_ENTRIES; i++) begin
            if (entry_valid[i] && entry_ip[i] == ip) return i;
        end
        return -1;
    endfunction

    function automatic t_reply resolve_request(t_req r);
        t_reply res;
        int idx;
        int i;
        logic [15:0] age;
        res = NO_REPLY;
        idx = -1;
        case (r.kind)
            K_LOOKUP: begin
                n_lookups++;
                idx = find_ip(r.ip);
                if (idx >= 0) begin
                    n_hits++;
                    res.found = 1'b1;
                    res.slot = idx[3:0];
                    res.mac = entry_mac[idx];
                    res.hwt = entry_hwt[idx];
                    res.flags = entry_flags[idx];
                end
            end
            K_UPDATE: begin
                n_updates++;
                idx = find_ip(r.ip);
                for (i = 0; i < N_ENTRIES && idx < 0; i++) begin
                    if (!entry_valid[i]) idx = i;
                end
                if (idx < 0) begin
                    n_full++;
                    res.status = 1'b1;
                end else begin
                    entry_valid[idx] = 1'b1;
                    entry_ip[idx] = r.ip;
                    entry_mac[idx] = r.mac;
                    entry_hwt[idx] = r.hwt;
                    entry_flags[idx] = r.flags;
                    entry_stamp[idx] = r.now;
                    res.slot = idx[3:0];
                end
            end
            K_CLEAR: begin
                n_clears++;
                entry_valid = '0;
            end
            default: begin
                n_flushes++;
                for (i = 0; i < N_ENTRIES && idx < 0; i++) begin
                    age = r.now - entry_stamp[i];
                    if (entry_valid[i] && age >= life_secs) begin
                        n_evictions++;
                        idx = i;
                        entry_valid[i] = 1'b0;
                        res.found = 1'b1;
                        res.slot = idx[3:0];
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_row make_row(t_kind k, logic [31:0] ip, logic [47:0] mac,
                                      logic [15:0] hwt, logic [7:0] flags,
                                      logic [15:0] now, bit pinned, t_reply want);
        t_row row;
        row.req = '{k, ip, mac, hwt, flags, now};
        row.pinned = pinned;
        row.want = want;
        return row;
    endfunction

    task automatic send_request(t_req r, bit pinned, t_reply want);
        t_reply pred;
        @(negedge i_clk);
        start <= 1'b1;
        i_kind <= r.kind;
        i_ip_address <= r.ip;
        i_mac_address <= r.mac;
        i_hw_type <= r.hwt;
        i_entry_flags <= r.flags;
        i_now_seconds <= r.now;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = resolve_request(r);
        pending_replies.push_back(pinned ? want : pred);
    endtask

    task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_lifetime(logic [15:0] value);
        logic [31:0] rd;
        apb_xfer(1'b1, ADDR_LIFETIME, {16'($urandom), value}, rd);
        life_secs = value;
        apb_xfer(1'b0, ADDR_LIFETIME, 32'h0, rd);
        if (rd[15:0] !== life_secs) begin
            $display("%0t: lifetime readback expected %0h got %0h", $time, life_secs, rd[15:0]);
            mismatches++;
        end
    endtask

    task automatic settle_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (N_ENTRIES + 4) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: result with no request pending, expected none got slot %0d",
                         $time, o_slot);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                check_field("found", 48'(want.found), 48'(o_found));
                check_field("status", 48'(want.status), 48'(o_status));
                check_field("slot", 48'(want.slot), 48'(o_slot));
                check_field("found_mac", want.mac, o_found_mac);
                check_field("found_hw_type", 48'(want.hwt), 48'(o_found_hw_type));
                check_field("found_flags", 48'(want.flags), 48'(o_found_flags));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("arp_cache_table: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] rd;
        logic [31:0] ip_pool [POOL_SIZE];
        logic [15:0] phase_life [N_PHASES];
        logic [15:0] now_clock;
        t_req r;
        t_kind k;
        int ph, n, i, sel, gap;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_kind = K_LOOKUP;
        i_ip_address = '0;
        i_mac_address = '0;
        i_hw_type = '0;
        i_entry_flags = '0;
        i_now_seconds = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        quiet_cycles = 0;
        entry_valid = '0;
        life_secs = LIFETIME_RESET;
        for (i = 0; i < N_ENTRIES; i++) begin
            entry_ip[i] = '0;
            entry_mac[i] = '0;
            entry_hwt[i] = '0;
            entry_flags[i] = '0;
            entry_stamp[i] = '0;
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extremes, overwrite, aging boundary and wrap
        plan.push_back(make_row(K_LOOKUP, 32'h0, '0, '0, '0, 16'h0, 1'b1, NO_REPLY));
        plan.push_back(make_row(K_FLUSH, 32'h0, '0, '0, '0, 16'hFFFF, 1'b1, NO_REPLY));
        plan.push_back(make_row(K_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF,
                                16'hFFFF, 1'b1, NO_REPLY));
        plan.push_back(make_row(K_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 16'h0, 1'b1,
                                '{1'b1, 1'b0, 4'd0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF}));
        plan.push_back(make_row(K_UPDATE, 32'h0, '0, '0, '0, 16'h0, 1'b1,
                                '{1'b0, 1'b0, 4'd1, 48'h0, 16'h0, 8'h0}));
        plan.push_back(make_row(K_UPDATE, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 16'h0806, 8'h5A,
                                16'h0100, 1'b0, NO_REPLY));
        plan.push_back(make_row(K_FLUSH, 32'h0, '0, '0, '0, 16'h012B, 1'b0, NO_REPLY));
        plan.push_back(make_row(K_FLUSH, 32'h0, '0, '0, '0, 16'h012C, 1'b0, NO_REPLY));
        plan.push_back(make_row(K_UPDATE, 32'h0A00_0001, 48'hA5A5_5A5A_0F0F, 16'h0001, 8'h81,
                                16'hFFF0, 1'b0, NO_REPLY));
        plan.push_back(make_row(K_FLUSH, 32'h0, '0, '0, '0, 16'h0010, 1'b0, NO_REPLY));
        // fill every free entry, then one more to hit a full table
        for (i = 0; i < N_ENTRIES - 1; i++) begin
            plan.push_back(make_row(K_UPDATE, 32'hC0A8_0000 + i, 48'({$urandom, $urandom}),
                                    16'($urandom), 8'($urandom), 16'h0020, 1'b0, NO_REPLY));
        end
        plan.push_back(make_row(K_UPDATE, 32'hDEAD_BEEF, '0, '0, '0, 16'h0021, 1'b1,
                                '{1'b0, 1'b1, 4'd0, 48'h0, 16'h0, 8'h0}));
        plan.push_back(make_row(K_LOOKUP, 32'hC0A8_0007, '0, '0, '0, 16'h0022, 1'b0, NO_REPLY));
        plan.push_back(make_row(K_CLEAR, 32'h0, '0, '0, '0, 16'h0022, 1'b1, NO_REPLY));
        plan.push_back(make_row(K_LOOKUP, 32'hC0A8_0007, '0, '0, '0, 16'h0023, 1'b1, NO_REPLY));

        foreach (plan[j]) send_request(plan[j].req, plan[j].pinned, plan[j].want);

        phase_life[0] = 16'd1;
        phase_life[1] = 16'hFFFF;
        phase_life[2] = 16'd0;
        phase_life[3] = 16'($urandom_range(2, 1000));
        phase_life[4] = LIFETIME_RESET;
        phase_life[5] = 16'($urandom_range(1, 65535));
        now_clock = 16'($urandom);

        for (ph = 0; ph < N_PHASES; ph++) begin
            settle_idle();
            if (ph == 3) apb_xfer(1'b1, ADDR_UNMAPPED, $urandom, rd);
            set_lifetime(phase_life[ph]);
            for (i = 0; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
            if (ph % 2 == 0) begin
                ip_pool[0] = 32'h0;
                ip_pool[1] = 32'hFFFF_FFFF;
            end
            for (n = 0; n < PHASE_REQUESTS; n++) begin
                // every third block of 40 requests runs back to back
                if ((n / 40) % 3 != 0) begin
                    sel = $urandom_range(0, 99);
                    gap = sel < 40 ? 0 : sel < 90 ? $urandom_range(1, 3) :
                          sel < 98 ? $urandom_range(4, 12) : $urandom_range(20, 60);
                    repeat (gap) begin
                        @(negedge i_clk);
                        start <= 1'b0;
                    end
                end
                sel = $urandom_range(0, 99);
                k = sel < 38 ? K_LOOKUP : sel < 78 ? K_UPDATE : sel < 97 ? K_FLUSH : K_CLEAR;
                if ($urandom_range(0, 99) < 3) now_clock = 16'($urandom);
                else now_clock = now_clock + 16'($urandom_range(0, 30));
                r.kind = k;
                r.ip = $urandom_range(0, 9) == 0 ? $urandom
                                                 : ip_pool[$urandom_range(0, POOL_SIZE - 1)];
                r.mac = 48'({$urandom, $urandom});
                r.hwt = 16'($urandom);
                r.flags = 8'($urandom);
                r.now = now_clock;
                send_request(r, 1'b0, NO_REPLY);
            end
        end

        settle_idle();
        $display("%0d requests: %0d lookups with %0d hits, %0d updates with %0d full",
                 n_lookups + n_updates + n_flushes + n_clears, n_lookups, n_hits,
                 n_updates, n_full);
        $display("%0d flushes with %0d evictions, %0d clears, over %0d lifetime settings",
                 n_flushes, n_evictions, n_clears, N_PHASES + 1);
        if (mismatches == 0) begin
            $display("arp_cache_table: match");
        end else begin
            $display("arp_cache_table: mismatch");
        end
        $finish;
    end

endmodule
